@@ hdl/tccw_pkg.sv @@
// Shared constants, codes and types for the text console character writer.
// No dependencies; the sequencer, top level and checker import this package.
`timescale 1ns / 1ps

package tccw_pkg;

    // Screen geometry
    localparam int COLUMNS = 80;
    localparam int ROWS    = 25;
    localparam int DEPTH   = ROWS * COLUMNS;

    // Derived widths: the column register also holds COLUMNS (wrap pending)
    localparam int ROW_W  = $clog2(ROWS);
    localparam int PROW_W = ROW_W + 1;
    localparam int COL_W  = $clog2(COLUMNS + 1);
    localparam int ADDR_W = $clog2(DEPTH);

    // Fixed field widths
    localparam int CELL_W = 16;
    localparam int CHAR_W = 8;
    localparam int ATTR_W = 8;
    localparam int REQ_W  = 2;
    localparam int RROW_W = 5;
    localparam int RCOL_W = 7;
    localparam int IDX_W  = 11;

    localparam int TAB_STOP = 4;

    localparam logic [CHAR_W-1:0] CH_BS    = 8'd8;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'd9;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'd10;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'd13;
    localparam logic [CHAR_W-1:0] CH_BLANK = 8'd32;

    localparam logic [ATTR_W-1:0] DEFAULT_ATTR = 8'd7;

    typedef enum logic [REQ_W-1:0] {
        REQ_PUT   = 2'd0,
        REQ_READ  = 2'd1,
        REQ_CLEAR = 2'd2
    } t_req;

    typedef enum logic [2:0] {
        S_WIPE,
        S_IDLE,
        S_RUN,
        S_BLANK,
        S_TAB,
        S_RDWAIT,
        S_CLEAR,
        S_DONE
    } t_state;

    typedef struct packed {
        logic              we;
        logic              re;
        logic [ADDR_W-1:0] addr;
        logic [CELL_W-1:0] wdata;
    } t_mem_req;

    typedef struct packed {
        logic [IDX_W-1:0]  cursor_index;
        logic [CHAR_W-1:0] cell_char;
        logic [ATTR_W-1:0] cell_attr;
    } t_result;

endpackage

@@ hdl/tccw_screen_ram.sv @@
// Single-port synchronous RAM holding the screen cells, with a registered read.
// Generic; no package dependency.
`timescale 1ns / 1ps

module tccw_screen_ram #(
    parameter int DATA_W = 16,
    parameter int DEPTH  = 2000,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_addr,
    input  logic [DATA_W-1:0] i_wdata,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_addr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/tccw_ctrl.sv @@
// Command sequencer: cursor, scroll offset, attribute register and the
// accesses to the screen RAM. Depends on tccw_pkg.
`timescale 1ns / 1ps

module tccw_ctrl (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [tccw_pkg::REQ_W-1:0]   i_req_type,
    input  logic [tccw_pkg::CHAR_W-1:0]  i_char_code,
    input  logic [tccw_pkg::RROW_W-1:0]  i_cell_row,
    input  logic [tccw_pkg::RCOL_W-1:0]  i_cell_col,
    input  logic                         i_cfg_we,
    input  logic [tccw_pkg::ATTR_W-1:0]  i_cfg_data,
    output tccw_pkg::t_mem_req           o_mem,
    input  logic [tccw_pkg::CELL_W-1:0]  i_mem_rdata,
    output logic                         o_res_valid,
    input  logic                         i_res_ready,
    output tccw_pkg::t_result            o_res
);

    import tccw_pkg::*;

    t_state              r_state, n_state;
    logic [REQ_W-1:0]    r_req, n_req;
    logic [CHAR_W-1:0]   r_char, n_char;
    logic [RROW_W-1:0]   r_rrow, n_rrow;
    logic [RCOL_W-1:0]   r_rcol, n_rcol;
    logic [ROW_W-1:0]    r_crow, n_crow;
    logic [COL_W-1:0]    r_ccol, n_ccol;
    logic [ROW_W-1:0]    r_top, n_top;
    logic [ATTR_W-1:0]   r_attr, n_attr;
    logic [ADDR_W-1:0]   r_cnt, n_cnt;
    logic [CHAR_W-1:0]   r_rd_char, n_rd_char;
    logic [ATTR_W-1:0]   r_rd_attr, n_rd_attr;

    logic [ROW_W-1:0]    lrow;
    logic [COL_W-1:0]    lcol;
    logic                use_lin;
    logic                do_nl;
    t_state              nl_ret;

    // Logical row maps to a physical row through the scroll offset
    function automatic logic [ADDR_W-1:0] f_cell_addr(
        input logic [ROW_W-1:0] top,
        input logic [ROW_W-1:0] row,
        input logic [COL_W-1:0] col
    );
        logic [PROW_W-1:0] prow;
        prow = PROW_W'(top) + PROW_W'(row);
        if (prow >= PROW_W'(ROWS)) begin
            prow = prow - PROW_W'(ROWS);
        end
        return ADDR_W'(int'(prow) * COLUMNS + int'(col));
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_WIPE;
            r_crow  <= '0;
            r_ccol  <= '0;
            r_top   <= '0;
            r_attr  <= DEFAULT_ATTR;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_crow  <= n_crow;
            r_ccol  <= n_ccol;
            r_top   <= n_top;
            r_attr  <= n_attr;
            r_cnt   <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req     <= n_req;
        r_char    <= n_char;
        r_rrow    <= n_rrow;
        r_rcol    <= n_rcol;
        r_rd_char <= n_rd_char;
        r_rd_attr <= n_rd_attr;
    end

    always_comb begin
        n_state   = r_state;
        n_req     = r_req;
        n_char    = r_char;
        n_rrow    = r_rrow;
        n_rcol    = r_rcol;
        n_crow    = r_crow;
        n_ccol    = r_ccol;
        n_top     = r_top;
        n_attr    = i_cfg_we ? i_cfg_data : r_attr;
        n_cnt     = r_cnt;
        n_rd_char = r_rd_char;
        n_rd_attr = r_rd_attr;

        lrow        = r_crow;
        lcol        = r_ccol;
        use_lin     = 1'b0;
        do_nl       = 1'b0;
        nl_ret      = S_DONE;
        o_in_ready  = 1'b0;
        o_res_valid = 1'b0;
        o_mem.we    = 1'b0;
        o_mem.re    = 1'b0;
        o_mem.wdata = {r_attr, CH_BLANK};

        case (r_state)
            S_WIPE, S_CLEAR: begin
                o_mem.we    = 1'b1;
                o_mem.wdata = {DEFAULT_ATTR, CH_BLANK};
                use_lin     = 1'b1;
                n_cnt       = r_cnt + ADDR_W'(1);
                if (r_cnt == ADDR_W'(DEPTH - 1)) begin
                    n_cnt   = '0;
                    n_state = (r_state == S_WIPE) ? S_IDLE : S_DONE;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_req     = i_req_type;
                    n_char    = i_char_code;
                    n_rrow    = i_cell_row;
                    n_rcol    = i_cell_col;
                    n_rd_char = '0;
                    n_rd_attr = '0;
                    n_state   = S_RUN;
                end
            end
            S_RUN: begin
                case (r_req)
                    REQ_PUT: begin
                        case (r_char)
                            CH_LF: begin
                                do_nl  = 1'b1;
                                nl_ret = S_DONE;
                            end
                            CH_CR: begin
                                n_ccol  = '0;
                                n_state = S_DONE;
                            end
                            CH_BS: begin
                                if (r_ccol == '0) begin
                                    if (r_crow != '0) begin
                                        n_crow = r_crow - ROW_W'(1);
                                        n_ccol = COL_W'(COLUMNS - 1);
                                    end
                                end else begin
                                    n_ccol = r_ccol - COL_W'(1);
                                end
                                lrow     = n_crow;
                                lcol     = n_ccol;
                                o_mem.we = 1'b1;
                                n_state  = S_DONE;
                            end
                            default: begin
                                if (r_ccol >= COL_W'(COLUMNS)) begin
                                    // take the pending wrap, then come back here
                                    do_nl  = 1'b1;
                                    nl_ret = S_RUN;
                                end else if (r_char == CH_TAB) begin
                                    n_state = S_TAB;
                                end else begin
                                    o_mem.we    = 1'b1;
                                    o_mem.wdata = {r_attr, r_char};
                                    n_ccol      = r_ccol + COL_W'(1);
                                    n_state     = S_DONE;
                                end
                            end
                        endcase
                    end
                    REQ_READ: begin
                        if (int'(r_rrow) < ROWS && int'(r_rcol) < COLUMNS) begin
                            lrow     = ROW_W'(r_rrow);
                            lcol     = COL_W'(r_rcol);
                            o_mem.re = 1'b1;
                            n_state  = S_RDWAIT;
                        end else begin
                            n_state = S_DONE;
                        end
                    end
                    REQ_CLEAR: begin
                        n_attr  = DEFAULT_ATTR;
                        n_crow  = '0;
                        n_ccol  = '0;
                        n_cnt   = '0;
                        n_state = S_CLEAR;
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            S_BLANK: begin
                // blank the new bottom row after a scroll
                lrow     = ROW_W'(ROWS - 1);
                lcol     = COL_W'(r_cnt);
                o_mem.we = 1'b1;
                n_cnt    = r_cnt + ADDR_W'(1);
                if (r_cnt == ADDR_W'(COLUMNS - 1)) begin
                    n_cnt   = '0;
                    n_state = (r_char == CH_LF) ? S_DONE : S_RUN;
                end
            end
            S_TAB: begin
                o_mem.we = 1'b1;
                n_ccol   = r_ccol + COL_W'(1);
                if ((r_ccol % COL_W'(TAB_STOP)) == COL_W'(TAB_STOP - 1) ||
                    r_ccol == COL_W'(COLUMNS - 1)) begin
                    n_state = S_DONE;
                end
            end
            S_RDWAIT: begin
                n_rd_char = i_mem_rdata[CHAR_W-1:0];
                n_rd_attr = i_mem_rdata[CELL_W-1:CHAR_W];
                n_state   = S_DONE;
            end
            S_DONE: begin
                o_res_valid = 1'b1;
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (do_nl) begin
            n_ccol = '0;
            if (r_crow < ROW_W'(ROWS - 1)) begin
                n_crow  = r_crow + ROW_W'(1);
                n_state = nl_ret;
            end else begin
                n_top   = (r_top == ROW_W'(ROWS - 1)) ? '0 : r_top + ROW_W'(1);
                n_cnt   = '0;
                n_state = S_BLANK;
            end
        end

        o_mem.addr = use_lin ? r_cnt : f_cell_addr(r_top, lrow, lcol);
    end

    assign o_res.cursor_index = IDX_W'(int'(r_crow) * COLUMNS + int'(r_ccol));
    assign o_res.cell_char    = r_rd_char;
    assign o_res.cell_attr    = r_rd_attr;

endmodule

@@ hdl/text_console_character_writer_core.sv @@
// Top level of the text console character writer: sequencer, screen RAM and
// result register. Depends on tccw_pkg, tccw_ctrl and tccw_screen_ram.
//
//  Channel   | Handshake          | Payload
//  ----------+--------------------+---------------------------------------------
//  request   | i_valid / o_ready  | i_req_type, i_char_code, i_cell_row, i_cell_col
//  result    | o_valid / i_ready  | o_cursor_index, o_cell_char, o_cell_attr
//  attribute | i_cfg_we           | i_cfg_data
//
// One item at a time through the sequencer; a scroll also blanks the new
// bottom row through the single RAM port, and a clear request rewrites every
// cell. After reset a clearing pass runs with o_ready low.
// The result register lets the next request enter while a result waits.
`timescale 1ns / 1ps

module text_console_character_writer_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [tccw_pkg::REQ_W-1:0]   i_req_type,
    input  logic [tccw_pkg::CHAR_W-1:0]  i_char_code,
    input  logic [tccw_pkg::RROW_W-1:0]  i_cell_row,
    input  logic [tccw_pkg::RCOL_W-1:0]  i_cell_col,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [tccw_pkg::IDX_W-1:0]   o_cursor_index,
    output logic [tccw_pkg::CHAR_W-1:0]  o_cell_char,
    output logic [tccw_pkg::ATTR_W-1:0]  o_cell_attr,
    input  logic                         i_cfg_we,
    input  logic [tccw_pkg::ATTR_W-1:0]  i_cfg_data
);

    import tccw_pkg::*;

    t_mem_req           mem_req;
    logic [CELL_W-1:0]  mem_rdata;
    logic               res_valid;
    logic               res_ready;
    t_result            res;

    logic               r_o_valid;
    t_result            r_out;

    tccw_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_valid),
        .o_in_ready  (o_ready),
        .i_req_type  (i_req_type),
        .i_char_code (i_char_code),
        .i_cell_row  (i_cell_row),
        .i_cell_col  (i_cell_col),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .o_mem       (mem_req),
        .i_mem_rdata (mem_rdata),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res)
    );

    tccw_screen_ram #(
        .DATA_W (CELL_W),
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_req.we),
        .i_re    (mem_req.re),
        .i_addr  (mem_req.addr),
        .i_wdata (mem_req.wdata),
        .o_rdata (mem_rdata)
    );

    // Load a new beat when the register is empty or being drained
    assign res_ready = !r_o_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (res_ready) begin
            r_o_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid && res_ready) begin
            r_out <= res;
        end
    end

    assign o_valid        = r_o_valid;
    assign o_cursor_index = r_out.cursor_index;
    assign o_cell_char    = r_out.cell_char;
    assign o_cell_attr    = r_out.cell_attr;

endmodule

@@ hdl/tccw_checker.sv @@
// Port-level checks for the text console character writer, bound to the top.
// Depends on tccw_pkg.
`timescale 1ns / 1ps

module tccw_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_valid,
    input logic                         o_ready,
    input logic [tccw_pkg::REQ_W-1:0]   i_req_type,
    input logic [tccw_pkg::CHAR_W-1:0]  i_char_code,
    input logic [tccw_pkg::RROW_W-1:0]  i_cell_row,
    input logic [tccw_pkg::RCOL_W-1:0]  i_cell_col,
    input logic                         o_valid,
    input logic                         i_ready,
    input logic [tccw_pkg::IDX_W-1:0]   o_cursor_index,
    input logic [tccw_pkg::CHAR_W-1:0]  o_cell_char,
    input logic [tccw_pkg::ATTR_W-1:0]  o_cell_attr,
    input logic                         i_cfg_we,
    input logic [tccw_pkg::ATTR_W-1:0]  i_cfg_data
);

    import tccw_pkg::*;

    // A waiting result beat stays until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid)
        else $error("result beat dropped before it was taken");

    // The clearing pass after reset keeps the request side closed
    a_reset_busy: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_ready)
        else $error("request accepted right after reset");

    // One request at a time: an accepted beat closes the request side
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("second request accepted while one is in work");

    // The cursor never leaves the screen plus the wrap position
    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> int'(o_cursor_index) <= (DEPTH % (1 << IDX_W)) ||
                    DEPTH >= (1 << IDX_W))
        else $error("cursor index beyond the last cell");

endmodule

bind text_console_character_writer_core tccw_checker u_tccw_checker (.*);
